@@ src/nsc_pkg.sv @@
// nsc_pkg: shared types, character constants and the proprietary name table
// for the NMEA sentence checker. No dependencies.
package nsc_pkg;

	localparam int STATUS_W = 4;
	localparam int FIELD_W  = 6;
	localparam int BYTE_W   = 8;

	localparam int DEFAULT_BUFFER_DEPTH = 128;
	localparam int DEFAULT_MAX_FIELDS   = 40;

	localparam int NAME_LEN   = 7;
	localparam int NAME_COUNT = 6;
	localparam int TAIL_LEN   = 5;
	localparam int MIN_SENTENCE_LEN = 6;

	localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;

	localparam logic [STATUS_W-1:0] STATUS_NONE    = 4'd0;
	localparam logic [STATUS_W-1:0] STATUS_ERROR   = 4'd1;
	localparam logic [STATUS_W-1:0] STATUS_RZA     = 4'd2;
	localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 4'd8;

	// Row order gives match priority and status code (STATUS_RZA + row).
	localparam logic [BYTE_W-1:0] NAME_TABLE [NAME_COUNT][NAME_LEN] = '{
		'{"P", "N", "V", "G", "R", "Z", "A"},
		'{"P", "N", "V", "G", "R", "Z", "B"},
		'{"P", "N", "V", "G", "V", "E", "R"},
		'{"P", "N", "V", "G", "N", "M", "E"},
		'{"P", "N", "V", "G", "R", "T", "K"},
		'{"P", "N", "V", "G", "C", "F", "G"}
	};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  field_count;
	} result_t;

	// Uppercase ASCII hex digit for a nibble.
	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
		logic [BYTE_W-1:0] base;
		base = (nib < 4'd10) ? 8'h30 : 8'h37;
		return base + {4'd0, nib};
	endfunction

endpackage

@@ src/nmea_sentence_checker.sv @@
// nmea_sentence_checker: top level, valid/stall handshake around the
// sentence state. Uses nsc_pkg and nsc_sentence.
//
// Takes one received character per transfer and returns exactly one result
// per character: status 0 for ordinary bytes, and on the byte that ends a
// sentence (line feed, or the byte that reaches BUFFER_DEPTH) either 1 for
// an error, 2..7 for a recognized sentence type or 8 for an unknown one.
// Each nonzero status comes with the field count. Throughput is one byte per
// clock unless the output stalls; the only loop is the running sentence
// state (XOR, five-byte tail, counters). A byte passes an input register,
// then the result register. The input register also acts as a skid slot,
// so one more byte is taken while a result waits on a stalled output.
module nmea_sentence_checker #(
	parameter int BUFFER_DEPTH = nsc_pkg::DEFAULT_BUFFER_DEPTH,
	parameter int MAX_FIELDS   = nsc_pkg::DEFAULT_MAX_FIELDS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rx_valid,
	output logic                          rx_stall,
	input  logic [nsc_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [nsc_pkg::STATUS_W-1:0]  status,
	output logic [nsc_pkg::FIELD_W-1:0]   field_count
);

	logic                       valid_s1;
	logic [nsc_pkg::BYTE_W-1:0] byte_s1;
	logic                       res_valid_q;
	nsc_pkg::result_t           result_q;
	nsc_pkg::result_t           result_d;
	logic                       advance;

	// s1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && !(res_valid_q && res_stall);
	assign rx_stall = valid_s1 && res_valid_q && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid)
			byte_s1 <= rx_byte;
	end

	nsc_sentence #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.MAX_FIELDS   (MAX_FIELDS)
	) u_sentence (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result_d;
	end

	assign res_valid   = res_valid_q;
	assign status      = result_q.status;
	assign field_count = result_q.field_count;

	// A byte held in s1 behind a stalled result is neither dropped nor replaced.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && res_stall |=> valid_s1 && $stable(byte_s1))
		else $error("s1 byte lost while output stalled");

	// Field count accompanies every nonzero status, and only those.
	a_fields_with_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((status == nsc_pkg::STATUS_NONE) == (field_count == '0)))
		else $error("field count does not match status");

	// Status stays within the defined codes.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> status <= nsc_pkg::STATUS_UNKNOWN)
		else $error("status code out of range");

endmodule

@@ src/nsc_sentence.sv @@
// nsc_sentence: per-sentence running state (position, XOR, tail history,
// name match, comma count) and the result for one byte. Uses nsc_pkg.
module nsc_sentence #(
	parameter int BUFFER_DEPTH = nsc_pkg::DEFAULT_BUFFER_DEPTH,
	parameter int MAX_FIELDS   = nsc_pkg::DEFAULT_MAX_FIELDS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [nsc_pkg::BYTE_W-1:0]  rx_byte,
	output nsc_pkg::result_t            result
);

	localparam int PosW = $clog2(BUFFER_DEPTH + 1);

	logic                           in_sentence_q, ins_d;
	logic [PosW-1:0]                pos_q, pos_d;
	logic [nsc_pkg::BYTE_W-1:0]     xor_q, xor_d;
	logic [nsc_pkg::BYTE_W-1:0]     hist_q [nsc_pkg::TAIL_LEN];
	logic [nsc_pkg::BYTE_W-1:0]     hist_d [nsc_pkg::TAIL_LEN];
	logic [nsc_pkg::NAME_COUNT-1:0] flags_q, flags_d;
	logic [nsc_pkg::FIELD_W-1:0]    cc_q, cc_d;
	logic                           star_q, star_d;

	logic [2:0]                     name_idx;
	logic [nsc_pkg::FIELD_W:0]      fields_sum;
	logic [nsc_pkg::FIELD_W-1:0]    fields;
	logic                           sum_ok;

	always_comb begin
		ins_d   = in_sentence_q;
		pos_d   = pos_q;
		xor_d   = xor_q;
		hist_d  = hist_q;
		flags_d = flags_q;
		cc_d    = cc_q;
		star_d  = star_q;
		result.status      = nsc_pkg::STATUS_NONE;
		result.field_count = '0;

		// '$' restarts, even mid-sentence
		if (rx_byte == nsc_pkg::CHAR_DOLLAR) begin
			ins_d   = 1'b1;
			pos_d   = '0;
			xor_d   = '0;
			hist_d  = '{default: '0};
			flags_d = '1;
			cc_d    = '0;
			star_d  = 1'b0;
		end

		name_idx = 3'(pos_d - PosW'(1));

		if (ins_d) begin
			if (pos_d != '0) begin
				if (pos_d <= PosW'(nsc_pkg::NAME_LEN)) begin
					for (int n = 0; n < nsc_pkg::NAME_COUNT; n++) begin
						if (nsc_pkg::NAME_TABLE[n][name_idx] != rx_byte)
							flags_d[n] = 1'b0;
					end
				end
				if (!star_d) begin
					if (rx_byte == nsc_pkg::CHAR_COMMA && cc_d != '1)
						cc_d = cc_d + 1'b1;
					else if (rx_byte == nsc_pkg::CHAR_STAR)
						star_d = 1'b1;
				end
				// byte leaving the five-byte tail joins the checksum
				xor_d = xor_d ^ hist_d[nsc_pkg::TAIL_LEN-1];
				for (int i = nsc_pkg::TAIL_LEN - 1; i > 0; i--)
					hist_d[i] = hist_d[i-1];
				hist_d[0] = rx_byte;
			end
			pos_d = pos_d + PosW'(1);
		end

		fields_sum = {1'b0, cc_d} + 7'd1;
		fields     = fields_sum[nsc_pkg::FIELD_W] ? '1 : fields_sum[nsc_pkg::FIELD_W-1:0];
		// tail is *HH\r\n: hist[3] high digit, hist[2] low digit
		sum_ok = (pos_d >= PosW'(nsc_pkg::MIN_SENTENCE_LEN)) &&
			(hist_d[3] == nsc_pkg::hex_char(xor_d[7:4])) &&
			(hist_d[2] == nsc_pkg::hex_char(xor_d[3:0]));

		if (ins_d) begin
			if (pos_d == PosW'(BUFFER_DEPTH)) begin
				ins_d = 1'b0;
				result.status      = nsc_pkg::STATUS_ERROR;
				result.field_count = fields;
			end else if (rx_byte == nsc_pkg::CHAR_LF) begin
				ins_d = 1'b0;
				result.field_count = fields;
				if (!sum_ok || fields >= nsc_pkg::FIELD_W'(MAX_FIELDS)) begin
					result.status = nsc_pkg::STATUS_ERROR;
				end else begin
					result.status = nsc_pkg::STATUS_UNKNOWN;
					for (int n = nsc_pkg::NAME_COUNT - 1; n >= 0; n--) begin
						if (flags_d[n])
							result.status = nsc_pkg::STATUS_RZA + nsc_pkg::STATUS_W'(n);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			pos_q         <= '0;
			xor_q         <= '0;
			hist_q        <= '{default: '0};
			flags_q       <= '1;
			cc_q          <= '0;
			star_q        <= 1'b0;
		end else if (step) begin
			in_sentence_q <= ins_d;
			pos_q         <= pos_d;
			xor_q         <= xor_d;
			hist_q        <= hist_d;
			flags_q       <= flags_d;
			cc_q          <= cc_d;
			star_q        <= star_d;
		end
	end

endmodule

@@ bench/nsc_result_checker.sv @@
// nsc_result_checker: watches both channels of nmea_sentence_checker, predicts
// one result per accepted byte and compares each returned transfer in order.
// Depends on nsc_pkg for widths, characters, status codes and the name table.
module nsc_result_checker #(
	parameter int BUFFER_DEPTH = nsc_pkg::DEFAULT_BUFFER_DEPTH,
	parameter int MAX_FIELDS   = nsc_pkg::DEFAULT_MAX_FIELDS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rx_valid,
	input  logic                         rx_stall,
	input  logic [nsc_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                         res_valid,
	input  logic                         res_stall,
	input  logic [nsc_pkg::STATUS_W-1:0] status,
	input  logic [nsc_pkg::FIELD_W-1:0]  field_count,
	output int                           fail_count,
	output int                           pending
);

	localparam logic [8*16-1:0] HEX_UPPER = "0123456789ABCDEF";

	// sentence scanner state
	logic                           sent_open;
	logic [7:0]                     sent_pos;
	logic [7:0]                     sum_xor;
	logic [7:0]                     tail [nsc_pkg::TAIL_LEN];
	logic [nsc_pkg::NAME_COUNT-1:0] name_hits;
	logic [nsc_pkg::FIELD_W-1:0]    commas;
	logic                           star_hit;

	nsc_pkg::result_t predicted_results [$];
	int               fails;

	function automatic logic [7:0] hex_digit(input int nib);
		return HEX_UPPER[8*(15-nib) +: 8];
	endfunction

	function automatic void open_sentence();
		int i;
		sent_open = 1'b1;
		sent_pos  = '0;
		sum_xor   = '0;
		for (i = 0; i < nsc_pkg::TAIL_LEN; i++)
			tail[i] = '0;
		name_hits = '1;
		commas    = '0;
		star_hit  = 1'b0;
	endfunction

	function automatic nsc_pkg::result_t advance_sentence(input logic [7:0] b);
		nsc_pkg::result_t r;
		int               fc;
		int               n;
		int               i;
		r = '0;
		if (b == nsc_pkg::CHAR_DOLLAR)
			open_sentence();
		if (sent_open) begin
			if (sent_pos >= 1) begin
				if (sent_pos <= nsc_pkg::NAME_LEN) begin
					for (n = 0; n < nsc_pkg::NAME_COUNT; n++)
						if (nsc_pkg::NAME_TABLE[n][sent_pos-1] != b)
							name_hits[n] = 1'b0;
				end
				if (!star_hit) begin
					if (b == nsc_pkg::CHAR_COMMA) begin
						if (commas != '1)
							commas = commas + 1'b1;
					end else if (b == nsc_pkg::CHAR_STAR) begin
						star_hit = 1'b1;
					end
				end
				sum_xor = sum_xor ^ tail[nsc_pkg::TAIL_LEN-1];
				for (i = nsc_pkg::TAIL_LEN - 1; i > 0; i--)
					tail[i] = tail[i-1];
				tail[0] = b;
			end
			sent_pos = sent_pos + 1'b1;
			fc = int'(commas) + 1;
			if (fc > 63)
				fc = 63;
			if (int'(sent_pos) == BUFFER_DEPTH) begin
				sent_open = 1'b0;
				r.status = nsc_pkg::STATUS_ERROR;
				r.field_count = nsc_pkg::FIELD_W'(fc);
			end else if (b == nsc_pkg::CHAR_LF) begin
				sent_open = 1'b0;
				r.field_count = nsc_pkg::FIELD_W'(fc);
				if (sent_pos < nsc_pkg::MIN_SENTENCE_LEN || fc >= MAX_FIELDS ||
				    tail[3] != hex_digit(int'(sum_xor[7:4])) ||
				    tail[2] != hex_digit(int'(sum_xor[3:0]))) begin
					r.status = nsc_pkg::STATUS_ERROR;
				end else begin
					// lowest row wins
					r.status = nsc_pkg::STATUS_UNKNOWN;
					for (n = nsc_pkg::NAME_COUNT - 1; n >= 0; n--)
						if (name_hits[n])
							r.status = nsc_pkg::STATUS_RZA + nsc_pkg::STATUS_W'(n);
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		nsc_pkg::result_t want;
		if (!arst_n) begin
			open_sentence();
			sent_open = 1'b0;
			predicted_results.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d fields %0d",
						$time, status, field_count);
					fails++;
				end else begin
					want = predicted_results.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						fails++;
					end
					if (field_count !== want.field_count) begin
						$display("%0t: field_count expected %0d actual %0d",
							$time, want.field_count, field_count);
						fails++;
					end
				end
			end
			if (rx_valid && !rx_stall)
				predicted_results.push_back(advance_sentence(rx_byte));
		end
		fail_count <= fails;
		pending    <= predicted_results.size();
	end

endmodule

@@ bench/tb_nmea_sentence_checker.sv @@
// tb_nmea_sentence_checker: stimulus and verdict for nmea_sentence_checker.
// Depends on nsc_pkg, the block under test and nsc_result_checker.
module tb_nmea_sentence_checker;

	localparam int BUFFER_DEPTH = nsc_pkg::DEFAULT_BUFFER_DEPTH;
	localparam int MAX_FIELDS   = nsc_pkg::DEFAULT_MAX_FIELDS;

	localparam logic [7:0] CHAR_CR = 8'h0D;

	localparam int RANDOM_BYTES = 1500;  // sentence bytes in the random part
	localparam int QUIET_BYTES  = 200;   // tail of the run with no idling
	localparam int PRESSURE_AT  = 600;   // where the long output hold-off starts
	localparam int LONG_HOLD    = 60;    // cycles of output hold-off
	localparam int DRAIN_CYCLES = 8;     // two-stage pipe, plus margin
	localparam int TIMEOUT      = 3_000_000;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         rx_valid    = 1'b0;
	logic                         rx_stall;
	logic [nsc_pkg::BYTE_W-1:0]   rx_byte     = '0;
	logic                         res_valid;
	logic                         res_stall   = 1'b0;
	logic [nsc_pkg::STATUS_W-1:0] status;
	logic [nsc_pkg::FIELD_W-1:0]  field_count;

	int fail_count;
	int pending;

	// idle odds: 0 means no idling, otherwise one chance in N per transfer for input gaps, per receiver check for stalls
	int gap_odds   = 0;
	int stall_odds = 0;
	bit hold_req   = 1'b0;

	// bytes of the sentence being built, sent in order
	logic [7:0] frame [$];

	always #5 clk = ~clk;

	nmea_sentence_checker #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.MAX_FIELDS  (MAX_FIELDS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.status     (status),
		.field_count(field_count)
	);

	nsc_result_checker #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.MAX_FIELDS  (MAX_FIELDS)
	) sentence_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.status     (status),
		.field_count(field_count),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// One byte transfer. The byte stays put while stalled; after the transfer
	// an idle burst may follow, with junk on the bus while valid is low.
	// rx_stall is read right after the edge, so it is the pre-edge value.
	task automatic send_byte(input logic [7:0] b);
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (rx_stall);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			rx_valid <= 1'b0;
			rx_byte  <= 8'($urandom);
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame.size(); i++)
			send_byte(frame[i]);
		frame.delete();
	endtask

	function automatic void push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			frame.push_back(s[i]);
	endfunction

	// XOR of everything after the '$'
	function automatic logic [7:0] frame_sum();
		logic [7:0] sum;
		int         i;
		sum = '0;
		for (i = 1; i < frame.size(); i++)
			sum = sum ^ frame[i];
		return sum;
	endfunction

	// "*HH\r\n" tail
	function automatic void push_tail(input logic [7:0] sum, input bit lower);
		string hx;
		hx = lower ? $sformatf("%02x", sum) : $sformatf("%02X", sum);
		frame.push_back(nsc_pkg::CHAR_STAR);
		frame.push_back(hx[0]);
		frame.push_back(hx[1]);
		frame.push_back(CHAR_CR);
		frame.push_back(nsc_pkg::CHAR_LF);
	endfunction

	function automatic logic [7:0] upper_letter();
		return 8'($urandom_range(8'h41, 8'h5A));
	endfunction

	// Field content: mostly plain printable text, sometimes a stray '*' (stops
	// the comma count early) or any byte at all, but never '$' or line feed.
	function automatic logic [7:0] body_char();
		logic [7:0] c;
		int         roll;
		roll = $urandom_range(0, 47);
		if (roll == 0)
			return nsc_pkg::CHAR_STAR;
		if (roll < 4) begin
			c = 8'($urandom);
			while (c == nsc_pkg::CHAR_DOLLAR || c == nsc_pkg::CHAR_LF)
				c = 8'($urandom);
			return c;
		end
		c = 8'($urandom_range(8'h20, 8'h7E));
		while (c == nsc_pkg::CHAR_DOLLAR || c == nsc_pkg::CHAR_COMMA ||
		       c == nsc_pkg::CHAR_STAR)
			c = 8'($urandom_range(8'h20, 8'h7E));
		return c;
	endfunction

	// Builds one sentence into frame. Most are well formed with random names
	// and fields; the rest are short, near-miss, overlong, badly summed,
	// lowercase, missing the star, or cut off so that the next '$' restarts.
	task automatic build_frame();
		int kind;
		int pick;
		int row;
		int slot;
		int n_commas;
		int target;
		int c;
		int i;
		logic [7:0] sum;
		frame.delete();
		frame.push_back(nsc_pkg::CHAR_DOLLAR);
		kind = $urandom_range(0, 99);

		// short sentence, or a line feed inside the name
		if (kind < 6) begin
			repeat ($urandom_range(0, 8))
				frame.push_back(body_char());
			frame.push_back(nsc_pkg::CHAR_LF);
			return;
		end

		// name: exact, one letter off, or some other talker/type
		pick = $urandom_range(0, 9);
		if (pick < nsc_pkg::NAME_COUNT) begin
			for (i = 0; i < nsc_pkg::NAME_LEN; i++)
				frame.push_back(nsc_pkg::NAME_TABLE[pick][i]);
		end else if (pick < 8) begin
			row  = $urandom_range(0, nsc_pkg::NAME_COUNT - 1);
			slot = $urandom_range(0, nsc_pkg::NAME_LEN - 1);
			for (i = 0; i < nsc_pkg::NAME_LEN; i++)
				frame.push_back(i == slot ? upper_letter() : nsc_pkg::NAME_TABLE[row][i]);
		end else begin
			repeat ($urandom_range(2, 6))
				frame.push_back(upper_letter());
		end
		// a name match ignores what follows the seventh byte
		if ($urandom_range(0, 7) == 0)
			frame.push_back(upper_letter());

		// fields: usually few, sometimes around the field limit or saturating
		pick = $urandom_range(0, 19);
		if (pick < 14)
			n_commas = $urandom_range(0, 8);
		else if (pick < 18)
			n_commas = $urandom_range(MAX_FIELDS - 4, MAX_FIELDS + 2);
		else
			n_commas = $urandom_range(60, 70);
		for (c = 0; c < n_commas; c++) begin
			frame.push_back(nsc_pkg::CHAR_COMMA);
			repeat ($urandom_range(0, n_commas > 20 ? 1 : 5))
				frame.push_back(body_char());
		end

		// length: line feed on the depth byte, one short of it, or past it
		pick = $urandom_range(0, 29);
		if (pick == 0)
			target = BUFFER_DEPTH;
		else if (pick == 1)
			target = BUFFER_DEPTH - 1;
		else if (pick == 2)
			target = BUFFER_DEPTH + $urandom_range(1, 20);
		else
			target = 0;
		while (frame.size() + nsc_pkg::TAIL_LEN < target)
			frame.push_back(upper_letter());

		sum  = frame_sum();
		pick = $urandom_range(0, 19);
		if (pick == 0)
			sum = sum ^ 8'(1 << $urandom_range(0, 7));
		push_tail(sum, pick == 1);
		if (pick == 2)
			frame[frame.size() - nsc_pkg::TAIL_LEN] = body_char();
		if (pick == 3) begin
			// cut off; the next '$' restarts
			target = $urandom_range(1, frame.size() - 1);
			while (frame.size() > target)
				void'(frame.pop_back());
		end
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request so
	// the pipe fills and the block stalls its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				res_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int frame_bytes;
		bit pressed;
		frame_bytes = 0;
		pressed = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bytes outside a sentence, then short sentences, a
		// restart, a known name and lowercase hex
		gap_odds   = 4;
		stall_odds = 4;
		send_byte(8'h00);
		send_byte(8'hFF);
		push_text("$\n");
		send_frame();
		push_text("$$\n");
		send_frame();
		push_text("$PNVGRZA");
		push_tail(frame_sum(), 1'b0);
		send_frame();
		push_text("$A,");
		push_tail(frame_sum(), 1'b1);
		send_frame();

		// random sentences with noise between them
		while (frame_bytes < RANDOM_BYTES) begin
			if (frame_bytes >= RANDOM_BYTES - QUIET_BYTES) begin
				gap_odds   = 0;
				stall_odds = 0;
			end else begin
				gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
				stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
			end
			if (!pressed && frame_bytes >= PRESSURE_AT) begin
				hold_req = 1'b1;
				pressed  = 1'b1;
			end
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom));
			build_frame();
			frame_bytes += frame.size();
			send_frame();
		end
		rx_valid <= 1'b0;

		// drain, then let the pipe settle so strays would show up
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
src/nsc_pkg.sv
src/nsc_sentence.sv
src/nmea_sentence_checker.sv
bench/nsc_result_checker.sv
bench/tb_nmea_sentence_checker.sv
